// File: rtl/core/cba_pkg.sv
// ----------------------------------------------------------------------------
// Continuation block assigner package
// Shared widths, register indexes, reset values and controller interface types.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int unsigned DefTableDepth = 64;

  localparam int unsigned PidW   = 16;
  localparam int unsigned LenW   = 13;
  localparam int unsigned BlockW = 32;
  localparam int unsigned SizeW  = 13;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_BLOCK_SIZE  = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_BLOCK = 1'd1;

  localparam logic [SizeW-1:0]  BlockSizeRst  = 13'd2048;
  localparam logic [BlockW-1:0] FirstBlockRst = 32'd0;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch the incoming record, restart the table scan
    logic search;    // scan step: issue one table read, compare the last one
    logic fin_hit;   // close a record whose parent was found
    logic fin_miss;  // close a record whose parent was not found
  } cba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;       // compared entry matches the parent id
    logic miss;      // every valid entry compared without a match
  } cba_stat_t;

endpackage

// File: rtl/core/cba_dpath.sv
// ----------------------------------------------------------------------------
// Continuation block assigner datapath
// Parent table memory, scan counter, block counter and result registers.
// ----------------------------------------------------------------------------
module cba_dpath import cba_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [PidW-1:0]     parent_dir_i,
  input  logic [LenW-1:0]     continuation_len_i,
  input  logic                is_root_i,
  input  cba_cmd_t            cmd_i,
  output cba_stat_t           stat_o,
  output logic [BlockW-1:0]   block_addr_o,
  output logic [LenW-1:0]     byte_offset_o,
  output logic                status_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = PidW + BlockW + LenW;

  // entry layout: {parent, block, fill}
  logic [EW-1:0]     mem_q [TABLE_DEPTH];
  logic [EW-1:0]     rd_q;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     wr_data;

  logic [SizeW-1:0]  block_size_q;
  logic [BlockW-1:0] next_block_q, next_block_d;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic              cmp_vld_q;
  logic [AW-1:0]     cmp_idx_q;

  logic [PidW-1:0]   pid_q;
  logic [LenW-1:0]   len_q;
  logic              root_q;

  logic [AW-1:0]     hit_idx_q;
  logic [BlockW-1:0] hit_block_q;
  logic [LenW-1:0]   hit_fill_q;

  logic [BlockW-1:0] addr_q, addr_d;
  logic [LenW-1:0]   offset_q, offset_d;
  logic              status_q, status_d;

  logic [PidW-1:0]   rd_parent;
  logic [BlockW-1:0] rd_block;
  logic [LenW-1:0]   rd_fill;
  logic              issue_done;
  logic              match;
  logic [LenW:0]     sum;
  logic              over;
  logic              tbl_room;

  assign rd_parent  = rd_q[EW-1 -: PidW];
  assign rd_block   = rd_q[LenW +: BlockW];
  assign rd_fill    = rd_q[LenW-1:0];
  assign issue_done = (idx_q == count_q);
  assign match      = cmp_vld_q && (rd_parent == pid_q);
  assign rd_en      = cmd_i.search && !issue_done;

  assign stat_o.hit  = match;
  assign stat_o.miss = !cmp_vld_q && issue_done;

  assign sum      = {1'b0, hit_fill_q} + {1'b0, len_q};
  assign over     = sum > {1'b0, block_size_q};
  assign tbl_room = count_q < CW'(TABLE_DEPTH);

  always_comb begin
    next_block_d = next_block_q;
    count_d      = count_q;
    addr_d       = addr_q;
    offset_d     = offset_q;
    status_d     = status_q;
    wr_en        = 1'b0;
    wr_addr      = hit_idx_q;
    wr_data      = {pid_q, next_block_q, len_q};
    if (cmd_i.fin_hit) begin
      wr_en    = 1'b1;
      status_d = 1'b0;
      if (over) begin
        // record would spill past the block end: open a fresh block
        addr_d       = next_block_q;
        offset_d     = '0;
        next_block_d = next_block_q + 1'b1;
        wr_data      = {pid_q, next_block_q, len_q};
      end else begin
        addr_d   = hit_block_q;
        offset_d = hit_fill_q;
        wr_data  = {pid_q, hit_block_q, sum[LenW-1:0]};
      end
    end else if (cmd_i.fin_miss) begin
      addr_d       = next_block_q;
      offset_d     = '0;
      status_d     = 1'b0;
      next_block_d = next_block_q + 1'b1;
      wr_addr      = count_q[AW-1:0];
      if (!root_q) begin
        if (tbl_room) begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end else begin
          status_d = 1'b1;
        end
      end
    end
    if (cfg_we_i && (cfg_index_i == CFG_FIRST_BLOCK)) begin
      next_block_d = cfg_data_i[BlockW-1:0];
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (rd_en) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeRst;
      next_block_q <= FirstBlockRst;
      count_q      <= '0;
      idx_q        <= '0;
      cmp_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_index_i == CFG_BLOCK_SIZE)) begin
        block_size_q <= cfg_data_i[SizeW-1:0];
      end
      next_block_q <= next_block_d;
      count_q      <= count_d;
      idx_q        <= idx_d;
      cmp_vld_q    <= rd_en;
    end
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q[AW-1:0];
    if (cmd_i.start) begin
      pid_q  <= parent_dir_i;
      len_q  <= continuation_len_i;
      root_q <= is_root_i;
    end
    if (cmd_i.search && match) begin
      hit_idx_q   <= cmp_idx_q;
      hit_block_q <= rd_block;
      hit_fill_q  <= rd_fill;
    end
    addr_q   <= addr_d;
    offset_q <= offset_d;
    status_q <= status_d;
  end

  assign block_addr_o  = addr_q;
  assign byte_offset_o = offset_q;
  assign status_o      = status_q;

endmodule

// File: rtl/core/cba_ctrl.sv
// ----------------------------------------------------------------------------
// Continuation block assigner controller
// Sequences accept, table scan and result hand-off; owns the stream handshakes.
// ----------------------------------------------------------------------------
module cba_ctrl import cba_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  cba_stat_t stat_i,
  output cba_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StHit    = 2'd2;
  localparam logic [1:0] StMiss   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_vld_q, out_vld_d;
  logic       out_free;

  // result register can take a new result this cycle
  assign out_free = !out_vld_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StSearch;
        end
      end
      StSearch: begin
        cmd_o.search = 1'b1;
        if (stat_i.hit) begin
          state_d = StHit;
        end else if (stat_i.miss) begin
          state_d = StMiss;
        end
      end
      StHit: begin
        if (out_free) begin
          cmd_o.fin_hit = 1'b1;
          state_d       = StIdle;
        end
      end
      StMiss: begin
        if (out_free) begin
          cmd_o.fin_miss = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_o.fin_hit || cmd_o.fin_miss) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_vld_q;

endmodule

// File: rtl/core/continuation_block_assigner_top.sv
// ----------------------------------------------------------------------------
// Continuation block assigner
// Places continuation records into blocks, packing records of one parent.
// ----------------------------------------------------------------------------
// Input stream carries one record per transfer: parent id and record length in
// tdata, the root flag in tuser. Output stream returns one transfer per record:
// block address and byte offset in tdata, table-full status in tuser.
// Configuration: cfg_we_i with cfg_index_i 0 sets the block size, 1 sets the
// first block address (and reloads the block counter at once).
// The scan compares a record with the parents held in the table (up to
// TABLE_DEPTH), reading one table entry per cycle from the single read port of
// the table memory. One record is scanned at a time: the next one is accepted
// once the controller is back in idle after the result has been loaded.
// Reset empties the table, sets block size 2048 and the block counter to 0;
// no clearing pass is needed.
// A stalled receiver holds the result in the output register; the next record
// is still accepted and scanned, and waits before completion until the
// pending result has been taken.
// ----------------------------------------------------------------------------
module continuation_block_assigner_top import cba_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // parent_dir[15:0], continuation_len[28:16]
  input  logic                s_axis_tuser,  // is_root
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,  // block_addr[31:0], byte_offset[44:32]
  output logic                m_axis_tuser   // status
);

  cba_cmd_t          cmd;
  cba_stat_t         stat;
  logic [BlockW-1:0] block_addr;
  logic [LenW-1:0]   byte_offset;
  logic              status;

  cba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cba_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .parent_dir_i       (s_axis_tdata[15:0]),
    .continuation_len_i (s_axis_tdata[28:16]),
    .is_root_i          (s_axis_tuser),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .block_addr_o       (block_addr),
    .byte_offset_o      (byte_offset),
    .status_o           (status)
  );

  assign m_axis_tdata = {3'b000, byte_offset, block_addr};
  assign m_axis_tuser = status;

endmodule

// File: tb/continuation_block_assigner_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Continuation block assigner checker
// Watches the configuration port and both streams. Keeps its own parent table
// and block counter and predicts each placement. Compares every output
// transfer with the oldest prediction and counts failures.
// ----------------------------------------------------------------------------
module continuation_block_assigner_checker import cba_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [31:0]         s_axis_tdata,  // parent_dir[15:0], continuation_len[28:16]
  input  logic                s_axis_tuser,  // is_root
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic [47:0]         m_axis_tdata,  // block_addr[31:0], byte_offset[44:32]
  input  logic                m_axis_tuser,  // status
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  typedef struct packed {
    logic [BlockW-1:0] block_addr;
    logic [LenW-1:0]   byte_offset;
    logic              status;
  } placement_t;

  placement_t placement_q[$];

  // own copy of the parent table and counters
  logic [PidW-1:0]   tbl_parent [TABLE_DEPTH];
  logic [BlockW-1:0] tbl_block  [TABLE_DEPTH];
  logic [LenW-1:0]   tbl_fill   [TABLE_DEPTH];
  int unsigned       tbl_used;
  logic [BlockW-1:0] free_block;
  logic [SizeW-1:0]  blk_size;

  function automatic placement_t place_record(input logic [PidW-1:0] pid,
                                              input logic [LenW-1:0] len,
                                              input logic root);
    placement_t  res;
    logic        hit;
    int unsigned idx;
    logic [LenW:0] sum;
    res = '0;
    hit = 1'b0;
    idx = 0;
    // first match from index 0 wins, root records included
    for (int unsigned i = 0; i < tbl_used; i++) begin
      if (!hit && tbl_parent[i] == pid) begin
        hit = 1'b1;
        idx = i;
      end
    end
    if (!hit) begin
      res.block_addr = free_block;
      free_block     = free_block + 1'b1;
      if (!root) begin
        if (tbl_used < TABLE_DEPTH) begin
          tbl_parent[tbl_used] = pid;
          tbl_block[tbl_used]  = res.block_addr;
          tbl_fill[tbl_used]   = len;
          tbl_used++;
        end else begin
          res.status = 1'b1;
        end
      end
    end else begin
      sum             = {1'b0, tbl_fill[idx]} + {1'b0, len};
      res.block_addr  = tbl_block[idx];
      res.byte_offset = tbl_fill[idx];
      if (sum > {1'b0, blk_size}) begin
        res.block_addr  = free_block;
        res.byte_offset = '0;
        free_block      = free_block + 1'b1;
        tbl_block[idx]  = res.block_addr;
        tbl_fill[idx]   = len;
      end else begin
        tbl_fill[idx] = sum[LenW-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placement_t want;
    if (!rst_ni) begin
      placement_q.delete();
      tbl_used     = 0;
      free_block   = FirstBlockRst;
      blk_size     = BlockSizeRst;
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BLOCK_SIZE:  blk_size   = cfg_data_i[SizeW-1:0];
          CFG_FIRST_BLOCK: free_block = cfg_data_i[BlockW-1:0];
          default: ;
        endcase
      end
      // result side first: a record accepted at this edge cannot finish here
      if (m_axis_tvalid && m_axis_tready) begin
        if (placement_q.size() == 0) begin
          $error("result with no record waiting: block_addr 0x%08h byte_offset %0d status %0d",
                 m_axis_tdata[31:0], m_axis_tdata[44:32], m_axis_tuser);
          fail_count_o++;
        end else begin
          want = placement_q.pop_front();
          if (m_axis_tdata[31:0] !== want.block_addr) begin
            $error("block_addr: expected 0x%08h, actual 0x%08h",
                   want.block_addr, m_axis_tdata[31:0]);
            fail_count_o++;
          end
          if (m_axis_tdata[44:32] !== want.byte_offset) begin
            $error("byte_offset: expected %0d, actual %0d",
                   want.byte_offset, m_axis_tdata[44:32]);
            fail_count_o++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        placement_q.push_back(place_record(s_axis_tdata[15:0], s_axis_tdata[28:16],
                                           s_axis_tuser));
      end
      pending_o = placement_q.size();
    end
  end

endmodule

// File: tb/tb_continuation_block_assigner_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Continuation block assigner testbench
// Directed records on the block and counter edges, then random record streams
// drawn from a growing parent pool under several block settings and stall
// patterns. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_continuation_block_assigner_top;
  import cba_pkg::*;

  localparam int unsigned TableDepth = DefTableDepth;
  localparam int unsigned PoolSize   = 80;
  localparam int unsigned SegItems   = 160;
  localparam int unsigned CycleLimit = 600000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata = '0;  // parent_dir[15:0], continuation_len[28:16]
  logic                s_axis_tuser = 1'b0;  // is_root
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [47:0]         m_axis_tdata;  // block_addr[31:0], byte_offset[44:32]
  logic                m_axis_tuser;  // status

  int unsigned pending;
  int unsigned fail_count;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle = 31;
  int unsigned recv_idle = 48;

  logic [PidW-1:0] parent_pool [PoolSize];
  int unsigned     seg_size  [6];
  logic [31:0]     seg_first [6];
  int unsigned     seg_pool  [6];

  continuation_block_assigner_top #(
    .TABLE_DEPTH(TableDepth)
  ) i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  continuation_block_assigner_checker #(
    .TABLE_DEPTH(TableDepth)
  ) i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  // called at a rising edge, returns at the edge of the transfer;
  // tvalid is left high so back-to-back records need no second assignment
  task automatic send_record(input logic [PidW-1:0] pid, input logic [LenW-1:0] len,
                             input logic root);
    logic rdy;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, len, pid};
    s_axis_tuser  <= root;
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
  endtask

  // wait until every placement has come back, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (TableDepth + 8) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [SizeW-1:0] size, input logic [31:0] first);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_BLOCK_SIZE;
    cfg_data_i  <= {{(CfgDataW-SizeW){1'b0}}, size};
    @(posedge clk_i);
    cfg_index_i <= CFG_FIRST_BLOCK;
    cfg_data_i  <= first;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned     pick;
    int unsigned     quarter;
    logic [PidW-1:0] pid;
    logic [LenW-1:0] len;
    logic            root;

    parent_pool[0] = '0;
    parent_pool[1] = '1;
    for (int unsigned k = 2; k < PoolSize; k++) parent_pool[k] = PidW'($urandom);
    seg_size  = '{4096, 1, $urandom_range(1, 4096), 512, 4095, $urandom_range(1, 4096)};
    seg_first = '{$urandom, 32'hFFFF_FFFF, 32'h0, $urandom, 32'h7FFF_FFFF, $urandom};
    seg_pool  = '{16, 32, 48, 64, PoolSize, PoolSize};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: exact fill, overflow, root miss and root hit
    send_record(16'h0000, 13'd0, 1'b0);
    send_record(16'h0000, 13'd2048, 1'b0);
    send_record(16'h0000, 13'd1, 1'b0);
    send_record(16'hFFFF, 13'd4096, 1'b0);
    send_record(16'hFFFF, 13'd0, 1'b0);
    send_record(16'h3039, 13'd100, 1'b1);
    send_record(16'h3039, 13'd100, 1'b1);
    send_record(16'h0000, 13'd5, 1'b1);
    send_record(16'h0007, 13'd1000, 1'b0);
    send_record(16'h0007, 13'd1000, 1'b0);
    send_record(16'h0007, 13'd48, 1'b0);
    send_record(16'h0007, 13'd1, 1'b0);
    drain();

    // zero block size, counter wraps past the top address
    apply_setting(13'd0, 32'hFFFF_FFFE);
    send_record(16'h0000, 13'd0, 1'b0);
    send_record(16'h0000, 13'd0, 1'b0);
    send_record(16'h0000, 13'd1, 1'b0);
    send_record(16'hFFFF, 13'd4096, 1'b0);
    send_record(16'h0009, 13'd0, 1'b0);
    send_record(16'h0009, 13'd0, 1'b1);
    send_record(16'h0009, 13'd8, 1'b0);
    send_record(16'hABCD, 13'd4096, 1'b1);
    drain();

    for (int unsigned seg = 0; seg < 6; seg++) begin
      send_idle = (seg < 2) ? 31 : (seg < 4) ? 48 : 0;
      recv_idle = (seg < 2) ? 48 : (seg < 4) ? 31 : 0;
      apply_setting(seg_size[seg][SizeW-1:0], seg_first[seg]);
      quarter = seg_size[seg] >> 2;
      for (int unsigned n = 0; n < SegItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          pid  = PidW'($urandom);
          root = 1'b1;
        end else if (pick < 7) begin
          pid  = PidW'($urandom);
          root = 1'b0;
        end else begin
          pid  = parent_pool[$urandom_range(seg_pool[seg] - 1)];
          root = ($urandom_range(19) == 0);
        end
        case ($urandom_range(9))
          0:       len = '0;
          1:       len = 13'd4096;
          2, 3, 4: len = LenW'($urandom_range(4096));
          default: len = LenW'($urandom_range(quarter));
        endcase
        send_record(pid, len, root);
      end
      drain();
    end

    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/cba_pkg.sv
rtl/core/cba_dpath.sv
rtl/core/cba_ctrl.sv
rtl/core/continuation_block_assigner_top.sv
tb/continuation_block_assigner_checker.sv
tb/tb_continuation_block_assigner_top.sv
